// ===== rtl/dte_pkg.sv =====
// shared types, constants and the month table for the date to epoch seconds unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int EPOCH_W  = 36;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	localparam int Q100_W  = 6;   // year / 100 is at most 40
	localparam int TOD_W   = 17;  // hour*3600 + minute*60 + second, field maxima
	localparam int YDAYS_W = 20;  // 365 * years since the epoch
	localparam int LEAPS_W = 11;
	localparam int MDAYS_W = 9;
	localparam int DAYS_W  = 21;  // signed day count, down to minus one
	localparam int DSECS_W = 39;  // signed days * 86400
	localparam int SUM_W   = 40;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [LEAPS_W-1:0] LEAPS_BEFORE_EPOCH = 11'd477;
	// x / 100 as (x * 5243) >> 19, exact for every 12-bit x
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam logic [17:0] SECS_PER_DAY = 18'd86400;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_YEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MONTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DAY   = 2'd2;

	localparam logic [YEAR_W-1:0]  LIMIT_YEAR_RST  = 12'd2038;
	localparam logic [MONTH_W-1:0] LIMIT_MONTH_RST = 4'd1;
	localparam logic [DAY_W-1:0]   LIMIT_DAY_RST   = 5'd19;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} limits_t;

	typedef struct packed {
		logic [YEAR_W-1:0]     year;
		logic [MONTH_W-1:0]    month;
		logic [DAY_W-1:0]      day;
		logic [HOUR_W-1:0]     hour;
		logic [MINUTE_W-1:0]   minute;
		logic [SECOND_W-1:0]   second;
	} date_t;

	typedef struct packed {
		logic               ok;
		logic [YEAR_W-1:0]  year;
		logic [YEAR_W-1:0]  y1;
		logic [YEAR_W-1:0]  yoff;
		logic [Q100_W-1:0]  q_y;
		logic [Q100_W-1:0]  q_y1;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [TOD_W-1:0]   tod;
	} front_t;

	typedef struct packed {
		logic                ok;
		logic [EPOCH_W-1:0]  secs;
	} result_t;

	typedef struct packed {
		logic               ok;
		logic [DAYS_W-1:0]  days;
		logic [TOD_W-1:0]   tod;
	} days_t;

	// days before month m in a common year; 13 to 15 carry on at 31 days each
	function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [MDAYS_W-1:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			4'd13:   d = 9'd365;
			4'd14:   d = 9'd396;
			4'd15:   d = 9'd427;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/date_time_to_epoch_seconds_unit.sv =====
// Gregorian date and time to seconds since 1970-01-01 00:00:00. Five register stages:
// range check and year/100 by reciprocal, leap count and month days, signed day total,
// days times 86400, then time of day, clamp and the output register. One transaction
// is taken every cycle unless all stages are full; back-pressure stalls only the
// stages that hold data, so bubbles are squeezed out. Years below 1970 or past the
// limit year, and limit-year dates off the limit month or past the limit day, give 0
// with the valid flag clear. The user must write the limit registers through the
// configuration port only while no transaction is in flight; the unit does not check.
// top level; depends on dte_pkg, dte_front, dte_days, dte_secs
`timescale 1ns / 1ps
`default_nettype none

module date_time_to_epoch_seconds_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
	input  wire  [dte_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// epoch_seconds[35:0], zero padding above
	output logic [dte_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// valid_res[0]
	output logic [0:0]                         m_tuser,
	input  wire                                cfg_wen,
	input  wire  [dte_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [dte_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import dte_pkg::*;

	limits_t limits_q;
	date_t   in_date;
	front_t  front_d;
	days_t   days_d;
	result_t res_d;
	logic    front_valid, front_ready;
	logic    days_valid, days_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.year  <= LIMIT_YEAR_RST;
			limits_q.month <= LIMIT_MONTH_RST;
			limits_q.day   <= LIMIT_DAY_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_LIMIT_YEAR:  limits_q.year  <= cfg_wdata[YEAR_W-1:0];
				REG_LIMIT_MONTH: limits_q.month <= cfg_wdata[MONTH_W-1:0];
				REG_LIMIT_DAY:   limits_q.day   <= cfg_wdata[DAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_date.year   = s_tdata[11:0];
	assign in_date.month  = s_tdata[15:12];
	assign in_date.day    = s_tdata[20:16];
	assign in_date.hour   = s_tdata[25:21];
	assign in_date.minute = s_tdata[31:26];
	assign in_date.second = s_tdata[37:32];

	dte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_date   (in_date),
		.limits    (limits_q),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_d)
	);

	dte_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_d),
		.out_valid (days_valid),
		.out_ready (days_ready),
		.out_data  (days_d)
	);

	dte_secs u_secs (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days_valid),
		.in_ready  (days_ready),
		.in_data   (days_d),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_d)
	);

	assign m_tdata = OUT_TDATA_W'(res_d.secs);
	assign m_tuser = res_d.ok;

endmodule

`default_nettype wire

// ===== rtl/dte_front.sv =====
// stage 1: range check, year / 100 by reciprocal and time-of-day seconds
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire dte_pkg::date_t   in_date,
	input  wire dte_pkg::limits_t limits,
	output logic                  out_valid,
	input  wire                   out_ready,
	output dte_pkg::front_t       out_data
);
	import dte_pkg::*;

	logic             v_s1;
	front_t           d_s1;
	front_t           nxt;
	logic             en;
	logic [24:0]      prod_y;
	logic [24:0]      prod_y1;
	logic [YEAR_W-1:0] y1;

	assign en       = !v_s1 || out_ready;
	assign in_ready = en;

	always_comb begin
		y1 = in_date.year - 12'd1;
		prod_y  = 25'(in_date.year) * 25'(DIV100_MUL);
		prod_y1 = 25'(y1) * 25'(DIV100_MUL);
		nxt.ok = (in_date.year >= EPOCH_YEAR) && (in_date.year <= limits.year) &&
			!((in_date.year == limits.year) &&
			  ((in_date.month != limits.month) || (in_date.day > limits.day)));
		nxt.year  = in_date.year;
		nxt.y1    = y1;
		nxt.yoff  = in_date.year - EPOCH_YEAR;
		nxt.q_y   = prod_y[DIV100_SHIFT +: Q100_W];
		nxt.q_y1  = prod_y1[DIV100_SHIFT +: Q100_W];
		nxt.month = in_date.month;
		nxt.day   = in_date.day;
		nxt.tod   = TOD_W'(in_date.hour) * TOD_W'(3600) + TOD_W'(in_date.minute) * TOD_W'(60)
			+ TOD_W'(in_date.second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

`default_nettype wire

// ===== rtl/dte_days.sv =====
// stages 2 and 3: leap year count, year and month days, signed day total
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_days (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire dte_pkg::front_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output dte_pkg::days_t       out_data
);
	import dte_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [YDAYS_W-1:0] ydays;
		logic [LEAPS_W-1:0] leaps;
		logic               leap_adj;
		logic [MDAYS_W-1:0] mdays;
		logic [TOD_W-1:0]   tod;
	} mid_t;

	logic   v_s2, v_s3;
	mid_t   d_s2, nxt2;
	days_t  d_s3, nxt3;
	logic   en2, en3;
	logic   is_leap;
	logic [YEAR_W-1:0] hund;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign in_ready = en2;

	always_comb begin
		// year % 100 == 0 when the year equals 100 * (year / 100)
		hund    = YEAR_W'(in_data.q_y) * YEAR_W'(100);
		is_leap = (in_data.year[1:0] == 2'b00) &&
			((in_data.year != hund) || (in_data.q_y[1:0] == 2'b00));
		nxt2.ok       = in_data.ok;
		nxt2.ydays    = YDAYS_W'(in_data.yoff) * YDAYS_W'(365);
		// leap years in 1 .. year-1
		nxt2.leaps    = LEAPS_W'(in_data.y1[YEAR_W-1:2]) - LEAPS_W'(in_data.q_y1)
			+ LEAPS_W'(in_data.q_y1[Q100_W-1:2]);
		nxt2.leap_adj = is_leap && (in_data.month >= 4'd3);
		nxt2.mdays    = days_before_month(in_data.month) + MDAYS_W'(in_data.day);
		nxt2.tod      = in_data.tod;
	end

	always_comb begin
		nxt3.ok   = d_s2.ok;
		nxt3.days = DAYS_W'(d_s2.ydays) + DAYS_W'(d_s2.leaps) - DAYS_W'(LEAPS_BEFORE_EPOCH)
			+ DAYS_W'(d_s2.mdays) + DAYS_W'(d_s2.leap_adj) - DAYS_W'(1);
		nxt3.tod  = d_s2.tod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= in_valid;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			d_s2 <= nxt2;
		end
		if (en3 && v_s2) begin
			d_s3 <= nxt3;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

`default_nettype wire

// ===== rtl/dte_secs.sv =====
// stages 4 and 5: days to seconds, time of day added, clamp and output register
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_secs (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire dte_pkg::days_t in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output dte_pkg::result_t    out_data
);
	import dte_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [DSECS_W-1:0] dsecs;
		logic [TOD_W-1:0]   tod;
	} dsec_t;

	logic    v_s4, v_s5;
	dsec_t   d_s4, nxt4;
	result_t d_s5, nxt5;
	logic    en4, en5;
	logic signed [SUM_W-1:0] total;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	always_comb begin
		nxt4.ok    = in_data.ok;
		nxt4.dsecs = DSECS_W'($signed(in_data.days) * $signed({1'b0, SECS_PER_DAY}));
		nxt4.tod   = in_data.tod;
	end

	always_comb begin
		total   = SUM_W'($signed(d_s4.dsecs)) + $signed(SUM_W'(d_s4.tod));
		nxt5.ok = d_s4.ok;
		// day zero in the epoch month can run below zero
		if (!d_s4.ok || total[SUM_W-1]) begin
			nxt5.secs = '0;
		end else begin
			nxt5.secs = total[EPOCH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) begin
				v_s4 <= in_valid;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			d_s4 <= nxt4;
		end
		if (en5 && v_s4) begin
			d_s5 <= nxt5;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = d_s5;

endmodule

`default_nettype wire

// ===== rtl/dte_checker.sv =====
// port-level checks for the date to epoch seconds unit, bound to the top level
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                s_tvalid,
	input wire                                s_tready,
	input wire [dte_pkg::IN_TDATA_W-1:0]      s_tdata,
	input wire                                m_tvalid,
	input wire                                m_tready,
	input wire [dte_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input wire [0:0]                          m_tuser,
	input wire                                cfg_wen,
	input wire [dte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input wire [dte_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import dte_pkg::*;

	// a rejected date carries no seconds
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("rejected date with non-zero seconds");

	// padding above the seconds field stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:EPOCH_W] == '0)
		else $error("output padding not zero");

	// the input side only stalls when every stage is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind date_time_to_epoch_seconds_unit dte_checker u_dte_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for date_time_to_epoch_seconds_unit: directed table, then random phases
// across several limit settings, each transaction checked against a typed value or an in-bench calendar model
// depends on dte_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_GAP   = 12;   // five pipeline stages plus margin

	typedef struct packed {
		logic [dte_pkg::YEAR_W-1:0]   year;
		logic [dte_pkg::MONTH_W-1:0]  month;
		logic [dte_pkg::DAY_W-1:0]    day;
		logic [dte_pkg::HOUR_W-1:0]   hour;
		logic [dte_pkg::MINUTE_W-1:0] minute;
		logic [dte_pkg::SECOND_W-1:0] second;
	} stamp_t;

	localparam int STAMP_W = $bits(stamp_t);

	typedef struct packed {
		logic                        ok;
		logic [dte_pkg::EPOCH_W-1:0] secs;
	} epoch_res_t;

	typedef struct {
		bit                           is_cfg;
		logic [dte_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [dte_pkg::CFG_DATA_W-1:0] reg_val;
		stamp_t                       stamp;
		bit                           typed;
		epoch_res_t                   known;
	} stim_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [dte_pkg::IN_TDATA_W-1:0]     s_tdata;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [dte_pkg::OUT_TDATA_W-1:0]    m_tdata;
	logic [0:0]                         m_tuser;
	logic                               cfg_wen;
	logic [dte_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [dte_pkg::CFG_DATA_W-1:0]     cfg_wdata;

	// bench copy of the limit registers
	logic [dte_pkg::YEAR_W-1:0]  lim_year  = dte_pkg::LIMIT_YEAR_RST;
	logic [dte_pkg::MONTH_W-1:0] lim_month = dte_pkg::LIMIT_MONTH_RST;
	logic [dte_pkg::DAY_W-1:0]   lim_day   = dte_pkg::LIMIT_DAY_RST;

	epoch_res_t pending_epochs[$];
	stim_row_t  stim_table[$];
	int         n_sent = 0;
	int         n_seen = 0;
	int         n_err = 0;
	int         n_cycles = 0;

	date_time_to_epoch_seconds_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit gregorian_leap(input longint y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// leap years in 1..n
	function automatic longint leaps_through(input longint n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// months past december keep going at 31 days each
	function automatic longint days_ahead_of_month(input logic [dte_pkg::MONTH_W-1:0] m);
		longint total;
		total = 0;
		for (int i = 1; i < m; i++) begin
			if (i == 2)
				total += 28;
			else if (i == 4 || i == 6 || i == 9 || i == 11)
				total += 30;
			else
				total += 31;
		end
		return total;
	endfunction

	function automatic epoch_res_t epoch_of(input stamp_t st);
		epoch_res_t res;
		longint y;
		longint days;
		longint secs;
		res = '0;
		y = longint'(st.year);
		if (st.year < 12'd1970 || st.year > lim_year)
			return res;
		if (st.year == lim_year && (st.month != lim_month || st.day > lim_day))
			return res;
		days = 365 * (y - 1970) + leaps_through(y - 1) - leaps_through(1969)
			+ days_ahead_of_month(st.month) + longint'(st.day) - 1;
		if (st.month >= 3 && gregorian_leap(y))
			days += 1;
		secs = days * 86400 + longint'(st.hour) * 3600 + longint'(st.minute) * 60
			+ longint'(st.second);
		if (secs < 0)
			secs = 0;
		res.ok = 1'b1;
		res.secs = secs[dte_pkg::EPOCH_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t known_row(input int y, input int mo, input int dd, input int h,
		input int mi, input int s, input bit ok, input longint secs);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.stamp.year = 12'(y);
		r.stamp.month = 4'(mo);
		r.stamp.day = 5'(dd);
		r.stamp.hour = 5'(h);
		r.stamp.minute = 6'(mi);
		r.stamp.second = 6'(s);
		r.typed = 1'b1;
		r.known.ok = ok;
		r.known.secs = secs[dte_pkg::EPOCH_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t plain_row(input int y, input int mo, input int dd, input int h,
		input int mi, input int s);
		stim_row_t r;
		r = known_row(y, mo, dd, h, mi, s, 1'b0, 0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t limit_row(input logic [dte_pkg::CFG_IDX_W-1:0] idx,
		input int val);
		stim_row_t r;
		r = known_row(0, 0, 0, 0, 0, 0, 1'b0, 0);
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = 12'(val);
		return r;
	endfunction

	function automatic stamp_t random_stamp();
		stamp_t st;
		int pick;
		int top;
		pick = $urandom_range(99);
		top = (lim_year < 12'd1970) ? 2100 : int'(lim_year);
		st.year = 12'($urandom_range(top, 1970));
		st.month = 4'($urandom_range(12, 1));
		st.day = 5'($urandom_range(31, 1));
		st.hour = 5'($urandom_range(23, 0));
		st.minute = 6'($urandom_range(59, 0));
		st.second = 6'($urandom_range(60, 0));
		if (pick < 10) begin
			st = STAMP_W'({$urandom, $urandom});
		end else if (pick < 35) begin
			// around the limit date
			st.year = lim_year;
			st.month = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 0)) : lim_month;
			st.day = 5'($urandom_range(31, 0));
		end else if (pick < 40) begin
			// first days after the epoch, day zero and oversized time of day
			st.year = 12'd1970;
			st.month = 4'($urandom_range(1, 0));
			st.day = 5'($urandom_range(1, 0));
			st.hour = 5'($urandom);
			st.minute = 6'($urandom);
			st.second = 6'($urandom);
		end
		return st;
	endfunction

	task automatic send_stamp(input stamp_t st, input bit typed, input epoch_res_t known);
		while (!(n_sent >= 900 && n_sent < 1100) && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, st.second, st.minute, st.hour, st.day, st.month, st.year};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		pending_epochs.push_back(typed ? known : epoch_of(st));
		n_sent++;
	endtask

	task automatic write_limit(input logic [dte_pkg::CFG_IDX_W-1:0] idx,
		input logic [dte_pkg::CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_epochs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			dte_pkg::REG_LIMIT_YEAR:  lim_year = val[dte_pkg::YEAR_W-1:0];
			dte_pkg::REG_LIMIT_MONTH: lim_month = val[dte_pkg::MONTH_W-1:0];
			dte_pkg::REG_LIMIT_DAY:   lim_day = val[dte_pkg::DAY_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off to back the pipeline up, and a stretch with no stalls
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!held && n_seen >= 400) begin
				held = 1'b1;
				stall_left = 300;
				m_tready <= 1'b0;
			end else if (n_seen >= 1300 && n_seen < 1500) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 11);
			end
		end
	end

	// outputs are stable at the falling edge; a transaction seen here completes at the next rise
	always @(negedge clk) begin
		epoch_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_epochs.size() == 0) begin
				$error("result with no date pending: epoch_seconds %0d valid_res %0d",
					m_tdata[dte_pkg::EPOCH_W-1:0], m_tuser[0]);
				n_err++;
			end else begin
				want = pending_epochs.pop_front();
				if (m_tdata[dte_pkg::EPOCH_W-1:0] !== want.secs) begin
					$error("epoch_seconds: expected %0d, actual %0d", want.secs,
						m_tdata[dte_pkg::EPOCH_W-1:0]);
					n_err++;
				end
				if (m_tuser[0] !== want.ok) begin
					$error("valid_res: expected %0d, actual %0d", want.ok, m_tuser[0]);
					n_err++;
				end
			end
			n_seen++;
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [dte_pkg::CFG_DATA_W-1:0] ly;
		logic [dte_pkg::CFG_DATA_W-1:0] lm;
		logic [dte_pkg::CFG_DATA_W-1:0] ld;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;

		// reset limits: 2038-01-19
		stim_table.push_back(known_row(1970, 1, 1, 0, 0, 0, 1'b1, 0));
		stim_table.push_back(known_row(1970, 1, 2, 0, 0, 0, 1'b1, 86400));
		stim_table.push_back(known_row(2000, 1, 1, 0, 0, 0, 1'b1, 946684800));
		stim_table.push_back(known_row(2038, 1, 19, 3, 14, 7, 1'b1, 2147483647));
		stim_table.push_back(known_row(1969, 12, 31, 23, 59, 59, 1'b0, 0));
		stim_table.push_back(known_row(0, 0, 0, 0, 0, 0, 1'b0, 0));
		stim_table.push_back(known_row(2038, 1, 20, 0, 0, 0, 1'b0, 0));
		stim_table.push_back(known_row(2038, 2, 1, 0, 0, 0, 1'b0, 0));
		stim_table.push_back(known_row(2039, 1, 1, 0, 0, 0, 1'b0, 0));
		stim_table.push_back(known_row(4095, 15, 31, 31, 63, 63, 1'b0, 0));
		// day zero at the epoch clamps to zero but stays valid
		stim_table.push_back(known_row(1970, 1, 0, 0, 0, 0, 1'b1, 0));
		stim_table.push_back(plain_row(1970, 1, 0, 31, 63, 63));
		stim_table.push_back(plain_row(2000, 2, 29, 12, 0, 0));
		stim_table.push_back(plain_row(2000, 3, 1, 0, 0, 0));
		stim_table.push_back(plain_row(2001, 3, 1, 0, 0, 0));
		stim_table.push_back(plain_row(1972, 12, 31, 23, 59, 60));
		stim_table.push_back(plain_row(1999, 0, 5, 1, 2, 3));
		stim_table.push_back(plain_row(1999, 13, 1, 0, 0, 0));
		stim_table.push_back(plain_row(1999, 14, 15, 0, 0, 0));
		stim_table.push_back(plain_row(2037, 15, 31, 31, 63, 63));
		stim_table.push_back(plain_row(2024, 2, 30, 0, 0, 0));
		stim_table.push_back(plain_row(2038, 1, 19, 31, 63, 63));
		// widest limits
		stim_table.push_back(limit_row(dte_pkg::REG_LIMIT_YEAR, 4095));
		stim_table.push_back(limit_row(dte_pkg::REG_LIMIT_MONTH, 12));
		stim_table.push_back(limit_row(dte_pkg::REG_LIMIT_DAY, 31));
		stim_table.push_back(plain_row(2100, 3, 1, 0, 0, 0));
		stim_table.push_back(plain_row(4095, 12, 31, 23, 59, 60));
		stim_table.push_back(plain_row(4095, 12, 31, 31, 63, 63));
		stim_table.push_back(known_row(4095, 11, 30, 0, 0, 0, 1'b0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg)
				write_limit(stim_table[i].reg_idx, stim_table[i].reg_val);
			else
				send_stamp(stim_table[i].stamp, stim_table[i].typed, stim_table[i].known);
		end

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					ly = dte_pkg::LIMIT_YEAR_RST;
					lm = dte_pkg::LIMIT_MONTH_RST;
					ld = dte_pkg::LIMIT_DAY_RST;
				end
				1: begin
					ly = 12'd4095;
					lm = 12'd12;
					ld = 12'd31;
				end
				2: begin
					ly = 12'd1970;
					lm = 12'd1;
					ld = 12'd1;
				end
				3: begin
					// below the epoch: every date is turned away
					ly = 12'd1000;
					lm = 12'd0;
					ld = 12'd0;
				end
				4: begin
					ly = 12'd2100;
					lm = 12'd15;
					ld = 12'd31;
				end
				5: begin
					// raw bits, upper bits of the narrow registers included
					ly = 12'($urandom);
					lm = 12'($urandom);
					ld = 12'($urandom);
				end
				default: begin
					ly = 12'($urandom_range(4095, 1970));
					lm = 12'($urandom_range(12, 1));
					ld = 12'($urandom_range(31, 1));
				end
			endcase
			write_limit(dte_pkg::REG_LIMIT_YEAR, ly);
			write_limit(dte_pkg::REG_LIMIT_MONTH, lm);
			write_limit(dte_pkg::REG_LIMIT_DAY, ld);
			repeat (175) send_stamp(random_stamp(), 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_epochs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dte_pkg.sv
rtl/dte_front.sv
rtl/dte_days.sv
rtl/dte_secs.sv
rtl/date_time_to_epoch_seconds_unit.sv
rtl/dte_checker.sv
bench/tb_top.sv
